@@ rtl/pats_pkg.sv @@
`timescale 1ns / 1ps
package pats_pkg;
    localparam int MAX_TASKS  = 16;
    localparam int SLOT_W     = $clog2(MAX_TASKS);
    localparam int TIME_BITS  = 32;
    localparam int PRIO_W     = 6;
    localparam int QUANT_W    = 8;
    localparam int STAT_W     = 32;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 120;
    localparam logic signed [PRIO_W-1:0] PRIO_MAX = PRIO_W'(20);
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = -PRIO_W'(20);
    localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(20);

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_CREATE = 3'd1;
    localparam logic [2:0] OP_EXIT   = 3'd2;
    localparam logic [2:0] OP_SET    = 3'd3;
    localparam logic [2:0] OP_GET    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BADSLOT = 2'd2;

    typedef struct packed {
        logic accept;
        logic exec;
        logic scan;
        logic sel;
        logic age;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic found;
        logic idx_last;
    } t_sts;
endpackage

@@ rtl/pats_ctrl.sv @@
`timescale 1ns / 1ps
module pats_ctrl import pats_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_SEL, S_AGE, S_FIN} t_state;
    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        if (r_valid && i_m_tready) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_sts.need_scan ? S_SCAN : S_FIN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                o_cmd.sel = 1'b1;
                n_state = i_sts.found ? S_AGE : S_FIN;
            end
            S_AGE: begin
                o_cmd.age = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_valid;
endmodule

@@ rtl/pats_dp.sv @@
`timescale 1ns / 1ps
module pats_dp import pats_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic [IN_W-1:0]  i_in_data,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic [OUT_W-1:0] o_out_data
);
    logic [QUANT_W-1:0]       r_quant;
    logic [MAX_TASKS-1:0]     r_valid;
    logic signed [PRIO_W-1:0] r_stat [MAX_TASKS];
    logic signed [PRIO_W-1:0] r_dyn  [MAX_TASKS];
    logic [QUANT_W-1:0]       r_ql   [MAX_TASKS];
    logic [TIME_BITS-1:0]     r_crt  [MAX_TASKS];
    logic [STAT_W-1:0]        r_cpu  [MAX_TASKS];
    logic [STAT_W-1:0]        r_act  [MAX_TASKS];
    logic [SLOT_W-1:0]        r_cur, r_cnt, r_idx, r_pick, r_tgt;
    logic [TIME_BITS-1:0]     r_sys, r_last;
    logic [2:0]               r_op;
    logic                     r_usecur, r_found;
    logic signed [PRIO_W-1:0] r_req, r_best;
    logic                     r_sw;
    logic [SLOT_W-1:0]        r_new;
    logic [PRIO_W-1:0]        r_prio;
    logic [1:0]               r_status;
    logic [STAT_W-1:0]        r_el, r_run, r_actv;

    logic [SLOT_W-1:0]        w_addr, w_free, w_prev;
    logic                     w_has_free, w_tgt_ok, w_quant_run;
    logic signed [PRIO_W-1:0] w_raw, w_sat;
    logic [TIME_BITS-1:0]     w_sys1;

    assign w_raw = i_in_data[13:8];
    assign w_sat = (w_raw > PRIO_MAX) ? PRIO_MAX : ((w_raw < PRIO_MIN) ? PRIO_MIN : w_raw);
    assign w_sys1 = r_sys + TIME_BITS'(1);
    assign w_tgt_ok = (r_tgt == '0) || r_valid[r_tgt];

    always_comb begin
        w_free = '0;
        w_has_free = 1'b0;
        w_prev = '0;
        for (int j = MAX_TASKS - 1; j >= 1; j--) begin
            if (!r_valid[j]) begin
                w_free = SLOT_W'(j);
                w_has_free = 1'b1;
            end
        end
        for (int j = 1; j < MAX_TASKS; j++) begin
            if (r_valid[j] && SLOT_W'(j) < r_cur) begin
                w_prev = SLOT_W'(j);
            end
        end
    end

    always_comb begin
        w_addr = r_cur;
        if (i_cmd.scan || i_cmd.age) begin
            w_addr = r_idx;
        end else if (i_cmd.sel) begin
            w_addr = r_pick;
        end else if (r_op == OP_CREATE) begin
            w_addr = w_free;
        end else if (r_op == OP_SET || r_op == OP_GET) begin
            w_addr = r_tgt;
        end
    end

    assign w_quant_run = (r_cur != '0) && (r_ql[r_cur] != '0);
    assign o_sts.need_scan = (r_op == OP_TICK) && (r_cnt != '0) && !w_quant_run;
    assign o_sts.found     = r_found;
    assign o_sts.idx_last  = (r_idx == SLOT_W'(MAX_TASKS - 1));

    // slot table, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            case (r_op)
                OP_TICK: begin
                    if (r_cnt != '0) begin
                        if (w_quant_run) begin
                            r_ql[w_addr] <= r_ql[w_addr] - QUANT_W'(1);
                        end else begin
                            r_cpu[w_addr] <= r_cpu[w_addr] + STAT_W'(w_sys1 - r_last);
                        end
                    end
                end
                OP_CREATE: begin
                    if (w_has_free) begin
                        r_stat[w_addr] <= '0;
                        r_dyn[w_addr]  <= '0;
                        r_ql[w_addr]   <= r_quant;
                        r_crt[w_addr]  <= r_sys;
                        r_cpu[w_addr]  <= '0;
                        r_act[w_addr]  <= '0;
                    end
                end
                OP_SET: begin
                    if (w_tgt_ok) begin
                        r_stat[w_addr] <= r_req;
                        if (!r_usecur) begin
                            r_dyn[w_addr] <= r_req;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.sel && r_found) begin
            r_dyn[w_addr] <= r_stat[w_addr];
            r_ql[w_addr]  <= r_quant;
            r_act[w_addr] <= r_act[w_addr] + STAT_W'(1);
        end
        if (i_cmd.age && r_valid[w_addr] && w_addr != r_pick && r_dyn[w_addr] > PRIO_MIN) begin
            r_dyn[w_addr] <= r_dyn[w_addr] - PRIO_W'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant <= QUANT_RESET;
            r_valid <= '0;
            r_cur   <= '0;
            r_cnt   <= '0;
            r_sys   <= '0;
            r_last  <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_quant <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_idx   <= SLOT_W'(1);
                r_found <= 1'b0;
                case (r_op)
                    OP_TICK: begin
                        r_sys <= w_sys1;
                        if (r_cnt == '0) begin
                            r_cur <= '0;
                        end
                    end
                    OP_CREATE: begin
                        if (w_has_free) begin
                            r_valid[w_free] <= 1'b1;
                            r_cnt <= r_cnt + SLOT_W'(1);
                        end
                    end
                    OP_EXIT: begin
                        if (r_cur != '0) begin
                            r_valid[r_cur] <= 1'b0;
                            r_cnt <= r_cnt - SLOT_W'(1);
                            r_cur <= w_prev;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.scan) begin
                r_idx <= r_idx + SLOT_W'(1);
                if (r_valid[w_addr] && r_dyn[w_addr] < r_best) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.sel) begin
                r_idx <= SLOT_W'(1);
                if (r_found) begin
                    r_cur  <= r_pick;
                    r_last <= r_sys;
                end
            end
            if (i_cmd.age) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
        end
    end

    // item and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_in_data[2:0];
            r_tgt    <= i_in_data[7] ? r_cur : i_in_data[6:3];
            r_usecur <= i_in_data[7];
            r_req    <= w_sat;
        end
        if (i_cmd.exec) begin
            r_best   <= PRIO_MAX;
            r_sw     <= 1'b0;
            r_new    <= '0;
            r_prio   <= '0;
            r_status <= ST_OK;
            r_el     <= '0;
            r_run    <= '0;
            r_actv   <= '0;
            case (r_op)
                OP_CREATE: begin
                    if (w_has_free) begin
                        r_new <= w_free;
                    end else begin
                        r_status <= ST_FULL;
                    end
                end
                OP_EXIT: begin
                    if (r_cur == '0) begin
                        r_status <= ST_BADSLOT;
                    end else begin
                        r_el   <= STAT_W'(r_sys - r_crt[w_addr]);
                        r_run  <= r_cpu[w_addr];
                        r_actv <= r_act[w_addr];
                    end
                end
                OP_SET: begin
                    if (!w_tgt_ok) begin
                        r_status <= ST_BADSLOT;
                    end
                end
                OP_GET: begin
                    if (!w_tgt_ok) begin
                        r_status <= ST_BADSLOT;
                    end else begin
                        r_prio <= r_stat[w_addr];
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.scan && r_valid[w_addr] && r_dyn[w_addr] < r_best) begin
            r_best <= r_dyn[w_addr];
            r_pick <= w_addr;
        end
        if (i_cmd.sel && r_found) begin
            r_sw <= 1'b1;
        end
        if (i_cmd.out_load) begin
            o_out_data <= {3'b000, r_cnt, r_actv, r_run, r_el, r_status, r_prio,
                           r_new, r_sw, r_cur};
        end
    end
endmodule

@@ rtl/priority_aging_task_scheduler_top.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Fields (low bit first)
// s (in)    in   tdata: operation[2:0] target_task[6:3] use_current[7] priority_req[13:8]
// m (out)   out  tdata: current_task[3:0] switched[4] new_task_slot[8:5] prio_read[14:9]
//                status[16:15] exit_elapsed[48:17] exit_run_time[80:49]
//                exit_activations[112:81] tasks_left[116:113]
// cfg       in   quantum_ticks[7:0], write strobe i_cfg_we
//
// One item at a time: most items pass through the accept, execute and result-load states,
// with the result registered behind them; a tick that reschedules scans all 15 user slots
// for the pick and, only when one qualifies, scans them again for aging.
// Synchronous active-low reset; slot valid bits clear at once, no clearing pass.
// A result held by a stalled sink lets the next item run up to its result stage,
// where it waits and holds off the input.
module priority_aging_task_scheduler_top import pats_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // operation, target_task, use_current, priority_req
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // current_task .. tasks_left, see table
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata
);
    t_cmd w_cmd;
    t_sts w_sts;

    pats_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pats_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (o_m_tdata)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready after accept");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[16:15] != 2'd3))
        else $error("illegal status");

    a_create_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[8:5] != '0) |-> (o_m_tdata[16:15] == ST_OK))
        else $error("new slot with error status");
endmodule
